### rtl/sotb_pkg.sv
// ----------------------------------------------------------------------------
// sotb_pkg
// Shared types, widths and codes of the stop order trigger book.
// ----------------------------------------------------------------------------
package sotb_pkg;

    localparam int TABLE_DEPTH    = 32;
    localparam int STRATEGY_COUNT = 16;
    localparam int IDX_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int SERIAL_W = 32;
    localparam int SYM_W    = 8;
    localparam int KIND_W   = 2;
    localparam int PRICE_W  = 32;
    localparam int VOL_W    = 16;
    localparam int STG_W    = 4;
    localparam int CNT_W    = 6;
    localparam int CMD_W    = 2;
    localparam int RES_W    = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLACE      = 2'd0,
        CMD_CANCEL     = 2'd1,
        CMD_CANCEL_STG = 2'd2,
        CMD_TICK       = 2'd3
    } cmd_e;

    typedef enum logic [RES_W-1:0] {
        RES_PLACED        = 3'd0,
        RES_FULL          = 3'd1,
        RES_CANCELLED     = 3'd2,
        RES_NOT_FOUND     = 3'd3,
        RES_TRIGGERED     = 3'd4,
        RES_TICK_DONE     = 3'd5,
        RES_STG_CANCELLED = 3'd6
    } res_kind_e;

    localparam logic [KIND_W-1:0] KIND_BUY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SELL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COVER = 2'd3;

    // One stored order
    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [SYM_W-1:0]    symbol;
        logic [KIND_W-1:0]   kind;
        logic [PRICE_W-1:0]  price;
        logic [VOL_W-1:0]    volume;
        logic [STG_W-1:0]    strategy;
    } slot_t;

    // One result beat, as handed from the sequencer to the output register
    typedef struct packed {
        logic                push;
        res_kind_e           result_kind;
        logic [SERIAL_W-1:0] order_serial;
        logic [SYM_W-1:0]    out_symbol;
        logic [KIND_W-1:0]   out_kind;
        logic [PRICE_W-1:0]  send_price;
        logic [VOL_W-1:0]    out_volume;
        logic [STG_W-1:0]    out_strategy;
        logic [CNT_W-1:0]    removed_count;
        logic                last;
    } result_t;

    function automatic logic is_buy_side(logic [KIND_W-1:0] kind);
        return (kind == KIND_BUY) || (kind == KIND_COVER);
    endfunction

endpackage

### rtl/stop_order_trigger_book.sv
// ----------------------------------------------------------------------------
// stop_order_trigger_book
// Table of working stop orders: place, cancel, strategy cancel, tick trigger.
// ----------------------------------------------------------------------------
// Usage:
//   One command beat enters on the s_ channel (valid/ready); each command
//   gives one or more result beats on the m_ channel, the final one with
//   m_last high. s_ready is high only while no command is in progress.
//   Work per command:
//     place                 one slot write
//     cancel, strategy      one full read pass of the table
//     tick                  one pass to find the triggered orders, then
//                           one pass per triggered order to pick the
//                           lowest serial still pending
//   The order payloads sit in a slot RAM with one read port; its one read per
//   cycle means each pass reads the slots in turn. Valid bits live in flip-flops.
//   Reset clears all valid bits and the serial counter at once; no clearing
//   pass is needed. When the receiver stalls, the result register holds its
//   beat and the sequencer waits in place until the register frees up.
// ----------------------------------------------------------------------------
module stop_order_trigger_book (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sotb_pkg::CMD_W-1:0]    s_cmd,
    input  logic [sotb_pkg::SYM_W-1:0]    s_symbol_id,
    input  logic [sotb_pkg::KIND_W-1:0]   s_order_kind,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_stop_price,
    input  logic [sotb_pkg::VOL_W-1:0]    s_volume,
    input  logic [sotb_pkg::STG_W-1:0]    s_strategy_id,
    input  logic [sotb_pkg::SERIAL_W-1:0] s_cancel_id,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_last_price,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_upper_limit,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_lower_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sotb_pkg::RES_W-1:0]    m_result_kind,
    output logic [sotb_pkg::SERIAL_W-1:0] m_order_serial,
    output logic [sotb_pkg::SYM_W-1:0]    m_out_symbol,
    output logic [sotb_pkg::KIND_W-1:0]   m_out_kind,
    output logic [sotb_pkg::PRICE_W-1:0]  m_send_price,
    output logic [sotb_pkg::VOL_W-1:0]    m_out_volume,
    output logic [sotb_pkg::STG_W-1:0]    m_out_strategy,
    output logic [sotb_pkg::CNT_W-1:0]    m_removed_count,
    output logic                          m_last
);
    import sotb_pkg::*;

    result_t          res;
    result_t          out_reg;
    logic             m_valid_reg;
    logic             res_space;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    slot_t            ram_rdata;

    // The result register takes a new beat when empty or being drained
    assign res_space = !m_valid_reg || m_ready;

    sotb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_symbol_id   (s_symbol_id),
        .s_order_kind  (s_order_kind),
        .s_stop_price  (s_stop_price),
        .s_volume      (s_volume),
        .s_strategy_id (s_strategy_id),
        .s_cancel_id   (s_cancel_id),
        .s_last_price  (s_last_price),
        .s_upper_limit (s_upper_limit),
        .s_lower_limit (s_lower_limit),
        .res_space     (res_space),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    sotb_slot_ram u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register: load on push, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.push) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = out_reg.result_kind;
    assign m_order_serial  = out_reg.order_serial;
    assign m_out_symbol    = out_reg.out_symbol;
    assign m_out_kind      = out_reg.out_kind;
    assign m_send_price    = out_reg.send_price;
    assign m_out_volume    = out_reg.out_volume;
    assign m_out_strategy  = out_reg.out_strategy;
    assign m_removed_count = out_reg.removed_count;
    assign m_last          = out_reg.last;

endmodule

### rtl/sotb_slot_ram.sv
// ----------------------------------------------------------------------------
// sotb_slot_ram
// Order payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sotb_slot_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [sotb_pkg::IDX_W-1:0]  waddr,
    input  sotb_pkg::slot_t             wdata,
    input  logic                        re,
    input  logic [sotb_pkg::IDX_W-1:0]  raddr,
    output sotb_pkg::slot_t             rdata
);
    import sotb_pkg::*;

    slot_t mem [TABLE_DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sotb_ctrl.sv
// ----------------------------------------------------------------------------
// sotb_ctrl
// Command sequencer: slot valid/hit bits, table scans, ordered emission.
// ----------------------------------------------------------------------------
module sotb_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sotb_pkg::CMD_W-1:0]    s_cmd,
    input  logic [sotb_pkg::SYM_W-1:0]    s_symbol_id,
    input  logic [sotb_pkg::KIND_W-1:0]   s_order_kind,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_stop_price,
    input  logic [sotb_pkg::VOL_W-1:0]    s_volume,
    input  logic [sotb_pkg::STG_W-1:0]    s_strategy_id,
    input  logic [sotb_pkg::SERIAL_W-1:0] s_cancel_id,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_last_price,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_upper_limit,
    input  logic [sotb_pkg::PRICE_W-1:0]  s_lower_limit,
    input  logic                          res_space,
    output sotb_pkg::result_t             res,
    output logic                          ram_we,
    output logic [sotb_pkg::IDX_W-1:0]    ram_waddr,
    output sotb_pkg::slot_t               ram_wdata,
    output logic                          ram_re,
    output logic [sotb_pkg::IDX_W-1:0]    ram_raddr,
    input  sotb_pkg::slot_t               ram_rdata
);
    import sotb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_SCAN,
        ST_MIN,
        ST_EMIT,
        ST_DONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    state_t                 state_reg, state_next;
    cmd_e                   cmd_reg, cmd_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [PRICE_W-1:0]     stop_reg, stop_next;
    logic [VOL_W-1:0]       vol_reg, vol_next;
    logic [STG_W-1:0]       stg_reg, stg_next;
    logic [SERIAL_W-1:0]    cid_reg, cid_next;
    logic [PRICE_W-1:0]     lastp_reg, lastp_next;
    logic [PRICE_W-1:0]     upper_reg, upper_next;
    logic [PRICE_W-1:0]     lower_reg, lower_next;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] hit_reg, hit_next;
    logic [SERIAL_W-1:0]    serial_cnt_reg, serial_cnt_next;

    logic [IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic                   issuing_reg, issuing_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;

    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    slot_t                  best_reg, best_next;

    logic                   table_full;
    logic [IDX_W-1:0]       free_idx;
    logic                   scan_end;
    logic                   trig;
    logic                   stg_known;
    logic [TABLE_DEPTH-1:0] hit_left;

    // Lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign table_full = &valid_reg;
    assign scan_end   = rd_vld_reg && (rd_idx_reg == LAST_IDX);
    assign trig       = is_buy_side(ram_rdata.kind) ? (lastp_reg >= ram_rdata.price)
                                                    : (lastp_reg <= ram_rdata.price);
    assign stg_known  = int'(stg_reg) < STRATEGY_COUNT;
    assign hit_left   = hit_reg & ~(TABLE_DEPTH'(1) << best_idx_reg);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        sym_next        = sym_reg;
        kind_next       = kind_reg;
        stop_next       = stop_reg;
        vol_next        = vol_reg;
        stg_next        = stg_reg;
        cid_next        = cid_reg;
        lastp_next      = lastp_reg;
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        serial_cnt_next = serial_cnt_reg;
        issue_idx_next  = issue_idx_reg;
        issuing_next    = issuing_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;

        s_ready   = 1'b0;
        res       = '0;
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = issue_idx_reg;

        // Read issue shared by both scan passes
        if ((state_reg == ST_SCAN || state_reg == ST_MIN) && issuing_reg) begin
            ram_re      = 1'b1;
            rd_vld_next = 1'b1;
            rd_idx_next = issue_idx_reg;
            if (issue_idx_reg == LAST_IDX) begin
                issuing_next = 1'b0;
            end else begin
                issue_idx_next = issue_idx_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = cmd_e'(s_cmd);
                    sym_next        = s_symbol_id;
                    kind_next       = s_order_kind;
                    stop_next       = s_stop_price;
                    vol_next        = s_volume;
                    stg_next        = s_strategy_id;
                    cid_next        = s_cancel_id;
                    lastp_next      = s_last_price;
                    upper_next      = s_upper_limit;
                    lower_next      = s_lower_limit;
                    found_next      = 1'b0;
                    count_next      = '0;
                    hit_next        = '0;
                    issue_idx_next  = '0;
                    issuing_next    = (cmd_e'(s_cmd) != CMD_PLACE);
                    state_next      = (cmd_e'(s_cmd) == CMD_PLACE) ? ST_PLACE : ST_SCAN;
                end
            end

            ST_PLACE: begin
                if (res_space) begin
                    res.push = 1'b1;
                    res.last = 1'b1;
                    if (table_full) begin
                        res.result_kind = RES_FULL;
                    end else begin
                        res.result_kind    = RES_PLACED;
                        res.order_serial   = serial_cnt_reg + SERIAL_W'(1);
                        serial_cnt_next    = serial_cnt_reg + SERIAL_W'(1);
                        ram_we             = 1'b1;
                        ram_wdata.serial   = serial_cnt_reg + SERIAL_W'(1);
                        ram_wdata.symbol   = sym_reg;
                        ram_wdata.kind     = kind_reg;
                        ram_wdata.price    = stop_reg;
                        ram_wdata.volume   = vol_reg;
                        ram_wdata.strategy = stg_reg;
                        valid_next[free_idx] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                if (rd_vld_reg && valid_reg[rd_idx_reg]) begin
                    case (cmd_reg)
                        CMD_CANCEL: begin
                            if (!found_reg && ram_rdata.serial == cid_reg) begin
                                valid_next[rd_idx_reg] = 1'b0;
                                found_next             = 1'b1;
                            end
                        end
                        CMD_CANCEL_STG: begin
                            if (stg_known && ram_rdata.strategy == stg_reg) begin
                                valid_next[rd_idx_reg] = 1'b0;
                                count_next             = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_TICK: begin
                            if (ram_rdata.symbol == sym_reg && trig) begin
                                hit_next[rd_idx_reg] = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (scan_end) begin
                    if (cmd_reg == CMD_TICK && hit_next != '0) begin
                        issue_idx_next  = '0;
                        issuing_next    = 1'b1;
                        best_found_next = 1'b0;
                        state_next      = ST_MIN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_MIN: begin
                // Strict compare keeps the lowest slot among equal serials
                if (rd_vld_reg && hit_reg[rd_idx_reg] &&
                    (!best_found_reg || ram_rdata.serial < best_reg.serial)) begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_next       = ram_rdata;
                end
                if (scan_end) begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (res_space) begin
                    res.push         = 1'b1;
                    res.result_kind  = RES_TRIGGERED;
                    res.order_serial = best_reg.serial;
                    res.out_symbol   = best_reg.symbol;
                    res.out_kind     = best_reg.kind;
                    res.send_price   = is_buy_side(best_reg.kind) ? upper_reg : lower_reg;
                    res.out_volume   = best_reg.volume;
                    res.out_strategy = best_reg.strategy;
                    hit_next                = hit_left;
                    valid_next[best_idx_reg] = 1'b0;
                    if (hit_left != '0) begin
                        issue_idx_next  = '0;
                        issuing_next    = 1'b1;
                        best_found_next = 1'b0;
                        state_next      = ST_MIN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (res_space) begin
                    res.push = 1'b1;
                    res.last = 1'b1;
                    case (cmd_reg)
                        CMD_CANCEL: begin
                            res.result_kind  = found_reg ? RES_CANCELLED : RES_NOT_FOUND;
                            res.order_serial = cid_reg;
                        end
                        CMD_CANCEL_STG: begin
                            res.result_kind   = RES_STG_CANCELLED;
                            res.removed_count = count_reg;
                        end
                        default: begin
                            res.result_kind   = RES_TICK_DONE;
                            res.removed_count = count_reg;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            hit_reg        <= '0;
            serial_cnt_reg <= '0;
            issuing_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            best_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            hit_reg        <= hit_next;
            serial_cnt_reg <= serial_cnt_next;
            issuing_reg    <= issuing_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
            best_found_reg <= best_found_next;
        end
        cmd_reg       <= cmd_next;
        sym_reg       <= sym_next;
        kind_reg      <= kind_next;
        stop_reg      <= stop_next;
        vol_reg       <= vol_next;
        stg_reg       <= stg_next;
        cid_reg       <= cid_next;
        lastp_reg     <= lastp_next;
        upper_reg     <= upper_next;
        lower_reg     <= lower_next;
        issue_idx_reg <= issue_idx_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
    end

    a_push_needs_space: assert property (@(posedge aclk) disable iff (!aresetn)
        res.push |-> res_space)
        else $error("result pushed into a full output register");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !rd_vld_reg && !issuing_reg)
        else $error("table read still in flight while idle");

    a_write_only_place: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_PLACE) && !table_full)
        else $error("slot write outside a place");

    a_emit_is_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> best_found_reg && hit_reg[best_idx_reg])
        else $error("emitting an order that is not pending");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && res_space |=> !valid_reg[$past(best_idx_reg)])
        else $error("triggered order left in the table");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stop_order_trigger_book testbench
// Drives place, cancel, strategy cancel and tick commands into the stop order
// book and checks every result beat against a predictor that keeps its own
// copy of the order book. A short directed run goes first, then random
// traffic with table floods and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import sotb_pkg::*;

    typedef struct {
        cmd_e                cmd;
        logic [SYM_W-1:0]    symbol;
        logic [KIND_W-1:0]   kind;
        logic [PRICE_W-1:0]  stop_price;
        logic [VOL_W-1:0]    volume;
        logic [STG_W-1:0]    strategy;
        logic [SERIAL_W-1:0] cancel_id;
        logic [PRICE_W-1:0]  last_price;
        logic [PRICE_W-1:0]  upper_limit;
        logic [PRICE_W-1:0]  lower_limit;
    } book_cmd_t;

    typedef struct {
        res_kind_e           res;
        logic [SERIAL_W-1:0] serial;
        logic [SYM_W-1:0]    symbol;
        logic [KIND_W-1:0]   okind;
        logic [PRICE_W-1:0]  price;
        logic [VOL_W-1:0]    volume;
        logic [STG_W-1:0]    strategy;
        logic [CNT_W-1:0]    count;
        logic                last;
    } book_beat_t;

    class order_book_scoreboard;
        bit                  live [TABLE_DEPTH];
        slot_t               book [TABLE_DEPTH];
        logic [SERIAL_W-1:0] serial_count;
        book_beat_t          expected_beats [$];
        int                  mismatches;
        int                  beats_checked;
        int                  triggers;
        int                  full_rejects;
        int                  misses;
        int                  peak_fired;
        int                  cmd_tally [4];

        function new();
            foreach (live[i]) live[i] = 1'b0;
            foreach (cmd_tally[i]) cmd_tally[i] = 0;
            serial_count  = '0;
            mismatches    = 0;
            beats_checked = 0;
            triggers      = 0;
            full_rejects  = 0;
            misses        = 0;
            peak_fired    = 0;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i]) if (live[i]) n++;
            return n;
        endfunction

        function logic [SERIAL_W-1:0] pick_live_serial();
            int picks [$];
            foreach (live[i]) if (live[i]) picks = {picks, i};
            if (picks.size() == 0) return $urandom;
            return book[picks[$urandom_range(0, picks.size() - 1)]].serial;
        endfunction

        // buy and cover fire on a rising market, sell and short on a falling one
        function bit buys_on_rise(logic [KIND_W-1:0] k);
            return (k == KIND_BUY) || (k == KIND_COVER);
        endfunction

        function void add_beat(res_kind_e res, logic [SERIAL_W-1:0] serial,
                               logic [SYM_W-1:0] symbol, logic [KIND_W-1:0] okind,
                               logic [PRICE_W-1:0] price, logic [VOL_W-1:0] volume,
                               logic [STG_W-1:0] strategy, logic [CNT_W-1:0] count,
                               logic last);
            book_beat_t b;
            b.res      = res;
            b.serial   = serial;
            b.symbol   = symbol;
            b.okind    = okind;
            b.price    = price;
            b.volume   = volume;
            b.strategy = strategy;
            b.count    = count;
            b.last     = last;
            expected_beats = {expected_beats, b};
        endfunction

        function void note_command(book_cmd_t c);
            int slot;
            int fired;
            int best;
            bit hit [TABLE_DEPTH];
            slot  = -1;
            fired = 0;
            cmd_tally[int'(c.cmd)]++;
            case (c.cmd)
                CMD_PLACE: begin
                    foreach (live[i]) if (!live[i] && slot < 0) slot = i;
                    if (slot < 0) begin
                        full_rejects++;
                        add_beat(RES_FULL, '0, '0, '0, '0, '0, '0, '0, 1'b1);
                    end else begin
                        serial_count = serial_count + 1'b1;
                        live[slot] = 1'b1;
                        book[slot].serial   = serial_count;
                        book[slot].symbol   = c.symbol;
                        book[slot].kind     = c.kind;
                        book[slot].price    = c.stop_price;
                        book[slot].volume   = c.volume;
                        book[slot].strategy = c.strategy;
                        add_beat(RES_PLACED, serial_count, '0, '0, '0, '0, '0, '0, 1'b1);
                    end
                end
                CMD_CANCEL: begin
                    // lowest matching slot goes first
                    foreach (live[i]) begin
                        if (live[i] && book[i].serial == c.cancel_id && slot < 0) slot = i;
                    end
                    if (slot >= 0) begin
                        live[slot] = 1'b0;
                        add_beat(RES_CANCELLED, c.cancel_id, '0, '0, '0, '0, '0, '0, 1'b1);
                    end else begin
                        misses++;
                        add_beat(RES_NOT_FOUND, c.cancel_id, '0, '0, '0, '0, '0, '0, 1'b1);
                    end
                end
                CMD_CANCEL_STG: begin
                    if (int'(c.strategy) < STRATEGY_COUNT) begin
                        foreach (live[i]) begin
                            if (live[i] && book[i].strategy == c.strategy) begin
                                live[i] = 1'b0;
                                fired++;
                            end
                        end
                    end
                    add_beat(RES_STG_CANCELLED, '0, '0, '0, '0, '0, '0, CNT_W'(fired), 1'b1);
                end
                CMD_TICK: begin
                    foreach (live[i]) begin
                        hit[i] = live[i] && (book[i].symbol == c.symbol) &&
                                 (buys_on_rise(book[i].kind) ?
                                      (c.last_price >= book[i].price) :
                                      (c.last_price <= book[i].price));
                        if (hit[i]) fired++;
                    end
                    // emit in ascending serial, equal serials by slot
                    repeat (fired) begin
                        best = -1;
                        foreach (hit[i]) begin
                            if (hit[i] && (best < 0 || book[i].serial < book[best].serial))
                                best = i;
                        end
                        hit[best]  = 1'b0;
                        live[best] = 1'b0;
                        add_beat(RES_TRIGGERED, book[best].serial, book[best].symbol,
                                 book[best].kind,
                                 buys_on_rise(book[best].kind) ? c.upper_limit
                                                               : c.lower_limit,
                                 book[best].volume, book[best].strategy, '0, 1'b0);
                    end
                    triggers += fired;
                    if (fired > peak_fired) peak_fired = fired;
                    add_beat(RES_TICK_DONE, '0, '0, '0, '0, '0, '0, CNT_W'(fired), 1'b1);
                end
                default: begin
                end
            endcase
        endfunction

        function string show_beat(book_beat_t b);
            return $sformatf({"res %0d serial %h sym %h kind %0d price %h vol %h ",
                              "stg %0d cnt %0d last %b"},
                             b.res, b.serial, b.symbol, b.okind, b.price, b.volume,
                             b.strategy, b.count, b.last);
        endfunction

        function void check_beat(book_beat_t got);
            book_beat_t want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing pending: %s", show_beat(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.res !== want.res || got.serial !== want.serial ||
                got.symbol !== want.symbol || got.okind !== want.okind ||
                got.price !== want.price || got.volume !== want.volume ||
                got.strategy !== want.strategy || got.count !== want.count ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result beat %0d mismatch at %0t", beats_checked,
                             $realtime);
                    $display("  expected %s", show_beat(want));
                    $display("  actual   %s", show_beat(got));
                end
            end
        endfunction
    endclass

    localparam int     ITEM_TARGET     = 370;
    localparam int     QUIET_TAIL      = 60;   // last commands run without idling
    localparam int     HOLD_OFF_ITEM   = 150;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     PAUSE_ITEM      = 260;
    localparam int     SETTLE_CYCLES   = 200;
    localparam longint TIMEOUT_NS      = 64'd25_000_000;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd           = '0;
    logic [SYM_W-1:0]    s_symbol_id     = '0;
    logic [KIND_W-1:0]   s_order_kind    = '0;
    logic [PRICE_W-1:0]  s_stop_price    = '0;
    logic [VOL_W-1:0]    s_volume        = '0;
    logic [STG_W-1:0]    s_strategy_id   = '0;
    logic [SERIAL_W-1:0] s_cancel_id     = '0;
    logic [PRICE_W-1:0]  s_last_price    = '0;
    logic [PRICE_W-1:0]  s_upper_limit   = '0;
    logic [PRICE_W-1:0]  s_lower_limit   = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [RES_W-1:0]    m_result_kind;
    logic [SERIAL_W-1:0] m_order_serial;
    logic [SYM_W-1:0]    m_out_symbol;
    logic [KIND_W-1:0]   m_out_kind;
    logic [PRICE_W-1:0]  m_send_price;
    logic [VOL_W-1:0]    m_out_volume;
    logic [STG_W-1:0]    m_out_strategy;
    logic [CNT_W-1:0]    m_removed_count;
    logic                m_last;

    order_book_scoreboard board = new();

    int sent_items   = 0;
    int idle_pct     = 0;    // chance in percent that either side idles
    bit hold_off_req = 1'b0; // ask the result side for one long hold-off

    stop_order_trigger_book i_dut (.*);

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout with %0d result beats pending", board.expected_beats.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random field helpers. Prices cluster around 1000 so ticks hit working
    // orders often, with the odd zero, all-ones or full-range value.
    // ------------------------------------------------------------------------
    function automatic logic [PRICE_W-1:0] random_price();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom;
            default: return 32'd968 + $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] random_symbol();
        case ($urandom_range(0, 19))
            0, 1:    return 8'hFF;
            2:       return SYM_W'($urandom_range(0, 255));
            default: return SYM_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] random_volume();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            default: return VOL_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Fill every field with noise; each command overrides the ones it uses
    function automatic book_cmd_t noise_cmd(cmd_e op);
        book_cmd_t c;
        c.cmd         = op;
        c.symbol      = SYM_W'($urandom_range(0, 255));
        c.kind        = KIND_W'($urandom_range(0, 3));
        c.stop_price  = $urandom;
        c.volume      = VOL_W'($urandom_range(0, 65535));
        c.strategy    = STG_W'($urandom_range(0, 15));
        c.cancel_id   = $urandom;
        c.last_price  = $urandom;
        c.upper_limit = $urandom;
        c.lower_limit = $urandom;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command side. Drive at the falling edge, hold valid and payload until
    // the beat is taken at a rising edge, then log it with the predictor.
    // ------------------------------------------------------------------------
    task automatic send_command(book_cmd_t c);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_cmd         <= c.cmd;
        s_symbol_id   <= c.symbol;
        s_order_kind  <= c.kind;
        s_stop_price  <= c.stop_price;
        s_volume      <= c.volume;
        s_strategy_id <= c.strategy;
        s_cancel_id   <= c.cancel_id;
        s_last_price  <= c.last_price;
        s_upper_limit <= c.upper_limit;
        s_lower_limit <= c.lower_limit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(c);
        sent_items++;
    endtask

    task automatic place_order(logic [SYM_W-1:0] sym, logic [KIND_W-1:0] kind,
                               logic [PRICE_W-1:0] stop, logic [VOL_W-1:0] vol,
                               logic [STG_W-1:0] stg);
        book_cmd_t c;
        c = noise_cmd(CMD_PLACE);
        c.symbol     = sym;
        c.kind       = kind;
        c.stop_price = stop;
        c.volume     = vol;
        c.strategy   = stg;
        send_command(c);
    endtask

    task automatic cancel_order(logic [SERIAL_W-1:0] id);
        book_cmd_t c;
        c = noise_cmd(CMD_CANCEL);
        c.cancel_id = id;
        send_command(c);
    endtask

    task automatic cancel_strategy(logic [STG_W-1:0] stg);
        book_cmd_t c;
        c = noise_cmd(CMD_CANCEL_STG);
        c.strategy = stg;
        send_command(c);
    endtask

    task automatic tick_market(logic [SYM_W-1:0] sym, logic [PRICE_W-1:0] last_px,
                               logic [PRICE_W-1:0] upper, logic [PRICE_W-1:0] lower);
        book_cmd_t c;
        c = noise_cmd(CMD_TICK);
        c.symbol      = sym;
        c.last_price  = last_px;
        c.upper_limit = upper;
        c.lower_limit = lower;
        send_command(c);
    endtask

    // Fill the book to the brim on one symbol, knock once on the full table,
    // then fire a tick that sets off every buy-side order of the flood.
    task automatic flood_symbol(logic [SYM_W-1:0] sym, bit clear_first);
        int n;
        if (clear_first) begin
            for (int s = 0; s < STRATEGY_COUNT; s++) cancel_strategy(STG_W'(s));
        end
        n = TABLE_DEPTH - board.live_count() + 1;
        repeat (n) begin
            place_order(sym, $urandom_range(0, 1) ? KIND_BUY : KIND_COVER,
                        $urandom_range(0, 1000), random_volume(),
                        STG_W'($urandom_range(0, 15)));
        end
        tick_market(sym, 32'd1000, $urandom, $urandom);
    endtask

    // Drop valid and hold off until every pending result beat is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_beats.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Decide ready at each falling edge: random short stalls,
    // plus one long hold-off on request that backs the book up into s_ready.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_len;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_len = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (stall_len - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sample each accepted result beat at the rising edge
    always @(posedge aclk) begin : result_monitor
        book_beat_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.res      = res_kind_e'(m_result_kind);
            seen.serial   = m_order_serial;
            seen.symbol   = m_out_symbol;
            seen.okind    = m_out_kind;
            seen.price    = m_send_price;
            seen.volume   = m_out_volume;
            seen.strategy = m_out_strategy;
            seen.count    = m_removed_count;
            seen.last     = m_last;
            board.check_beat(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [SERIAL_W-1:0] victim;
        int                  pick;
        int                  phase;
        int                  last_phase;
        bit                  hold_off_done;
        bit                  pause_done;

        last_phase    = -1;
        hold_off_done = 1'b0;
        pause_done    = 1'b0;

        // hold reset low, then release it at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 20;

        // Empty book: tick yields only done, cancels find nothing
        tick_market(8'd7, 32'd1000, '1, '0);
        cancel_order('0);
        cancel_strategy('0);

        // One order of each kind on symbol 7 and two on 255, extremes of price, volume, strategy
        place_order(8'd7, KIND_BUY,   32'd1000, 16'd1,     4'd0);
        place_order(8'd7, KIND_SELL,  32'd1000, 16'hFFFF,  4'd15);
        place_order(8'd7, KIND_SHORT, '1,       16'h5555,  4'd5);
        place_order(8'd7, KIND_COVER, '0,       16'hAAAA,  4'd10);
        place_order(8'hFF, KIND_BUY,  '1,       16'h00FF,  4'd3);
        place_order(8'hFF, KIND_SELL, '0,       16'hFF00,  4'd12);

        // Sell, short and cover fire just under the buy stop; then buy on equality
        tick_market(8'd7, 32'd999,  '1, '0);
        tick_market(8'd7, 32'd1000, 32'hAAAA_AAAA, 32'h5555_5555);

        // Extreme prices on symbol 255: miss, buy at all-ones, sell at zero
        tick_market(8'hFF, 32'hFFFF_FFFE, $urandom, $urandom);
        tick_market(8'hFF, '1, 32'h1234_5678, 32'h8765_4321);
        tick_market(8'hFF, '0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

        // Cancel by id, twice, and an id never issued
        place_order(8'd3, KIND_BUY,   32'd500, 16'd20, 4'd9);
        victim = board.serial_count;
        place_order(8'd3, KIND_SELL,  32'd500, 16'd30, 4'd9);
        place_order(8'd4, KIND_COVER, 32'd100, 16'd40, 4'd9);
        place_order(8'd3, KIND_SHORT, 32'd600, 16'd50, 4'd2);
        cancel_order(victim);
        cancel_order(victim);
        cancel_order('1);

        // Strategy cancel with hits, then again with none left
        cancel_strategy(4'd9);
        cancel_strategy(4'd9);

        // Short fires on equality
        tick_market(8'd3, 32'd600, $urandom, $urandom);

        // Empty the book, fill it, reject on full, fire all 32 in one tick
        flood_symbol(8'd42, 1'b1);

        // Random traffic, mostly well-formed: live ids, hot symbols
        while (sent_items < ITEM_TARGET) begin
            phase = sent_items / 40;
            if (sent_items >= ITEM_TARGET - QUIET_TAIL) begin
                idle_pct = 0;
            end else if (phase != last_phase) begin
                last_phase = phase;
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 12;
                    default: idle_pct = 35;
                endcase
            end
            if (!hold_off_done && sent_items >= HOLD_OFF_ITEM) begin
                hold_off_done = 1'b1;
                hold_off_req  = 1'b1;
            end
            if (!pause_done && sent_items >= PAUSE_ITEM) begin
                pause_done = 1'b1;
                drain_results();
            end

            pick = $urandom_range(0, 199);
            if (pick < 3) begin
                flood_symbol(random_symbol(), 1'b0);
            end else if (pick < 90) begin
                place_order(random_symbol(), KIND_W'($urandom_range(0, 3)), random_price(),
                            random_volume(), STG_W'($urandom_range(0, 15)));
            end else if (pick < 126) begin
                case ($urandom_range(0, 5))
                    0:       cancel_order(board.serial_count + 1'b1);
                    1:       cancel_order($urandom);
                    default: cancel_order(board.pick_live_serial());
                endcase
            end else if (pick < 140) begin
                cancel_strategy(STG_W'($urandom_range(0, 15)));
            end else begin
                tick_market(random_symbol(), random_price(), $urandom, $urandom);
            end
        end

        // Drop valid, let the last results drain, then wait out the pipeline
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d commands (%0d place, %0d cancel, %0d strategy cancel, %0d tick)",
                 sent_items, board.cmd_tally[int'(CMD_PLACE)],
                 board.cmd_tally[int'(CMD_CANCEL)], board.cmd_tally[int'(CMD_CANCEL_STG)],
                 board.cmd_tally[int'(CMD_TICK)]);
        $display("run: %0d beats, %0d fired, %0d full rejects, %0d unknown ids, peak %0d/tick",
                 board.beats_checked, board.triggers, board.full_rejects, board.misses,
                 board.peak_fired);
        if (board.mismatches == 0 && board.expected_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("ERROR: %0d mismatches, %0d beats still pending",
                     board.mismatches, board.expected_beats.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
